/* hdl/wcs_pkg.sv */
// Package for the weighted CDF sampler: sizes, command and status codes, state type.
package wcs_pkg;

  localparam int unsigned MaxEntries = 256;
  localparam int unsigned WeightBits = 48;
  localparam int unsigned IdxW = $clog2(MaxEntries);
  localparam int unsigned CntW = $clog2(MaxEntries + 1);
  localparam int unsigned CumW = 56;
  localparam int unsigned KeyW = 160;
  localparam int unsigned RowW = KeyW + WeightBits;
  localparam int unsigned RandW = 64;
  localparam int unsigned DivCntW = $clog2(RandW + 1);

  typedef enum logic [1:0] {
    CmdClear  = 2'd0,
    CmdLoad   = 2'd1,
    CmdSample = 2'd2,
    CmdNone   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    StCleared  = 3'd0,
    StLoaded   = 3'd1,
    StFull     = 3'd2,
    StSelected = 3'd3,
    StNone     = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    SIdle,
    SScanRd,
    SScan,
    SShiftRd,
    SShiftWr,
    SSum,
    SDiv,
    SSrchRd,
    SSrch,
    SPickRd,
    SPick,
    SOut
  } state_e;

endpackage

/* hdl/weighted_cdf_sampler.sv */
// Weighted CDF sampler: sorted weight table in memory, modulo and lower-bound search.
//
//  channel | valid   | stall   | payload
//  request | valid_i | stall_o | cmd_i, addr_bytes_*_i, entry_weight_i, rand_value_i
//  result  | valid_o | stall_i | status_o, sel_bytes_*_o, sel_weight_o
//
// A load scans the table up to the insert slot (SScanRd and SScan for each
// entry), shifts the tail up (SShiftRd and SShiftWr for each entry, so scan and
// shift pass the table once) and rebuilds the running sums in SSum. A sample
// runs a restoring modulo of the 64-bit random value by the total, then a
// binary search (SSrchRd and SSrch for each step) over the sum memory. Reset
// empties the table at once; no clearing pass.
// One request is in work at a time; the result register holds under stall_i.
module weighted_cdf_sampler (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         valid_i,
  output logic         stall_o,
  input  logic [1:0]   cmd_i,
  input  logic [63:0]  addr_bytes_0_7_i,
  input  logic [63:0]  addr_bytes_8_15_i,
  input  logic [31:0]  addr_bytes_16_19_i,
  input  logic [47:0]  entry_weight_i,
  input  logic [63:0]  rand_value_i,
  output logic         valid_o,
  input  logic         stall_i,
  output logic [2:0]   status_o,
  output logic [63:0]  sel_bytes_0_7_o,
  output logic [63:0]  sel_bytes_8_15_o,
  output logic [31:0]  sel_bytes_16_19_o,
  output logic [47:0]  sel_weight_o
);

  localparam int unsigned IdxW = wcs_pkg::IdxW;
  localparam int unsigned CntW = wcs_pkg::CntW;
  localparam int unsigned CumW = wcs_pkg::CumW;
  localparam int unsigned RowW = wcs_pkg::RowW;
  localparam int unsigned WB = wcs_pkg::WeightBits;

  // Row layout: weight in the top bits, then the 160-bit key; compares as one number.
  logic [RowW-1:0] row_mem [wcs_pkg::MaxEntries];
  logic [CumW-1:0] cum_mem [wcs_pkg::MaxEntries];

  wcs_pkg::state_e state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CumW-1:0] total_q, total_d;
  logic [CntW-1:0] i_q, i_d;
  logic [CntW-1:0] lo_q, lo_d, hi_q, hi_d;
  logic [RowW-1:0] new_q, new_d;
  logic [CumW-1:0] run_q, run_d;
  logic [63:0]     rem_q, rem_d;
  logic [63:0]     quo_q, quo_d;
  logic [wcs_pkg::DivCntW-1:0] dcnt_q, dcnt_d;
  logic [RowW-1:0] row_rd_q;
  logic [CumW-1:0] cum_rd_q;

  logic            row_we, cum_we, row_re, cum_re;
  logic [IdxW-1:0] row_wa, row_ra, cum_wa, cum_ra;
  logic [RowW-1:0] row_wd;
  logic [CumW-1:0] cum_wd;

  logic            out_v_q;
  wcs_pkg::status_e out_st_q, res_st_q, res_st_d;
  logic [RowW-1:0] out_row_q, res_row_q, res_row_d;
  logic            out_load;

  logic [CntW-1:0] mid;
  logic [64:0]     trial;
  logic [CumW:0]   sum_w;

  always_ff @(posedge clk_i) begin
    if (row_we) row_mem[row_wa] <= row_wd;
    if (row_re) row_rd_q <= row_mem[row_ra];
  end

  always_ff @(posedge clk_i) begin
    if (cum_we) cum_mem[cum_wa] <= cum_wd;
    if (cum_re) cum_rd_q <= cum_mem[cum_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wcs_pkg::SIdle;
      count_q <= '0;
      total_q <= '0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      total_q <= total_d;
      if (out_load) out_v_q <= 1'b1;
      else if (!stall_i) out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q <= i_d;
    lo_q <= lo_d;
    hi_q <= hi_d;
    new_q <= new_d;
    run_q <= run_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    dcnt_q <= dcnt_d;
    res_st_q <= res_st_d;
    res_row_q <= res_row_d;
    if (out_load) begin
      out_st_q <= res_st_q;
      out_row_q <= res_row_q;
    end
  end

  assign stall_o = (state_q != wcs_pkg::SIdle);
  assign mid = lo_q + ((hi_q - lo_q) >> 1);
  // Restoring division step: the quotient register shifts the dividend in.
  assign trial = {rem_q, quo_q[63]} - {9'd0, total_q};
  assign sum_w = {1'b0, run_q} + {{(CumW + 1 - WB){1'b0}}, row_rd_q[RowW-1 -: WB]};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      wcs_pkg::SIdle: begin
        if (valid_i) begin
          unique case (wcs_pkg::cmd_e'(cmd_i))
            wcs_pkg::CmdLoad:
              state_d = (count_q == CntW'(wcs_pkg::MaxEntries)) ? wcs_pkg::SOut
                      : (count_q == '0) ? wcs_pkg::SShiftWr : wcs_pkg::SScanRd;
            wcs_pkg::CmdSample:
              state_d = (count_q == '0 || total_q == '0) ? wcs_pkg::SOut : wcs_pkg::SDiv;
            default: state_d = wcs_pkg::SOut;
          endcase
        end
      end
      wcs_pkg::SScanRd: state_d = wcs_pkg::SScan;
      wcs_pkg::SScan: begin
        if (row_rd_q > new_q) state_d = (i_q == count_q) ? wcs_pkg::SShiftWr
                                                         : wcs_pkg::SShiftRd;
        else if (i_q + 1'b1 == count_q) state_d = wcs_pkg::SShiftWr;
        else state_d = wcs_pkg::SScanRd;
      end
      wcs_pkg::SShiftRd: state_d = wcs_pkg::SShiftWr;
      wcs_pkg::SShiftWr: state_d = (hi_q == lo_q) ? wcs_pkg::SSum : wcs_pkg::SShiftRd;
      wcs_pkg::SSum: state_d = (i_q == count_q) ? wcs_pkg::SOut : wcs_pkg::SSum;
      wcs_pkg::SDiv: state_d = (dcnt_q == '0) ? wcs_pkg::SSrchRd : wcs_pkg::SDiv;
      wcs_pkg::SSrchRd: state_d = (lo_q < hi_q) ? wcs_pkg::SSrch : wcs_pkg::SPickRd;
      wcs_pkg::SSrch: state_d = wcs_pkg::SSrchRd;
      wcs_pkg::SPickRd: state_d = wcs_pkg::SPick;
      wcs_pkg::SPick: state_d = wcs_pkg::SOut;
      wcs_pkg::SOut: state_d = (out_v_q && stall_i) ? wcs_pkg::SOut : wcs_pkg::SIdle;
      default: state_d = wcs_pkg::SIdle;
    endcase
  end

  always_comb begin
    count_d = count_q;
    total_d = total_q;
    i_d = i_q;
    lo_d = lo_q;
    hi_d = hi_q;
    new_d = new_q;
    run_d = run_q;
    rem_d = rem_q;
    quo_d = quo_q;
    dcnt_d = dcnt_q;
    row_we = 1'b0;
    row_wa = '0;
    row_wd = new_q;
    row_re = 1'b0;
    row_ra = '0;
    cum_we = 1'b0;
    cum_wa = '0;
    cum_wd = run_q;
    cum_re = 1'b0;
    cum_ra = '0;
    res_st_d = res_st_q;
    res_row_d = res_row_q;
    unique case (state_q)
      wcs_pkg::SIdle: begin
        new_d = {entry_weight_i[WB-1:0], addr_bytes_0_7_i, addr_bytes_8_15_i,
                 addr_bytes_16_19_i};
        i_d = '0;
        lo_d = '0;
        hi_d = count_q;
        rem_d = '0;
        quo_d = rand_value_i;
        dcnt_d = wcs_pkg::DivCntW'(wcs_pkg::RandW - 1);
        res_st_d = wcs_pkg::StNone;
        res_row_d = '0;
        if (valid_i) begin
          unique case (wcs_pkg::cmd_e'(cmd_i))
            wcs_pkg::CmdClear: begin
              count_d = '0;
              total_d = '0;
              res_st_d = wcs_pkg::StCleared;
            end
            wcs_pkg::CmdLoad: begin
              if (count_q == CntW'(wcs_pkg::MaxEntries)) res_st_d = wcs_pkg::StFull;
            end
            default: ;
          endcase
        end
      end
      wcs_pkg::SScanRd: begin
        row_re = 1'b1;
        row_ra = i_q[IdxW-1:0];
      end
      wcs_pkg::SScan: begin
        // lo marks the insert slot; hi walks down from the top during the shift.
        if (row_rd_q > new_q) begin
          lo_d = i_q;
          hi_d = count_q;
        end else if (i_q + 1'b1 == count_q) begin
          lo_d = count_q;
          hi_d = count_q;
        end else begin
          i_d = i_q + 1'b1;
        end
      end
      wcs_pkg::SShiftRd: begin
        row_re = 1'b1;
        row_ra = IdxW'(hi_q - 1'b1);
      end
      wcs_pkg::SShiftWr: begin
        row_we = 1'b1;
        if (hi_q == lo_q) begin
          row_wa = lo_q[IdxW-1:0];
          row_wd = new_q;
          count_d = count_q + 1'b1;
          i_d = '0;
          run_d = '0;
        end else begin
          row_wa = hi_q[IdxW-1:0];
          row_wd = row_rd_q;
          hi_d = hi_q - 1'b1;
        end
      end
      wcs_pkg::SSum: begin
        // Read at i in this cycle; the data lands the next cycle and is summed then.
        if (i_q != count_q) begin
          row_re = 1'b1;
          row_ra = i_q[IdxW-1:0];
        end
        if (i_q != '0) begin
          run_d = sum_w[CumW] ? {CumW{1'b1}} : sum_w[CumW-1:0];
          cum_we = 1'b1;
          cum_wa = IdxW'(i_q - 1'b1);
          cum_wd = run_d;
        end
        if (i_q == count_q) begin
          total_d = run_d;
          res_st_d = wcs_pkg::StLoaded;
        end else begin
          i_d = i_q + 1'b1;
        end
      end
      wcs_pkg::SDiv: begin
        quo_d = {quo_q[62:0], ~trial[64]};
        rem_d = trial[64] ? {rem_q[62:0], quo_q[63]} : trial[63:0];
        dcnt_d = dcnt_q - 1'b1;
      end
      wcs_pkg::SSrchRd: begin
        cum_re = 1'b1;
        cum_ra = mid[IdxW-1:0];
      end
      wcs_pkg::SSrch: begin
        if ({8'd0, cum_rd_q} < rem_q) lo_d = mid + 1'b1;
        else hi_d = mid;
      end
      wcs_pkg::SPickRd: begin
        row_re = 1'b1;
        row_ra = lo_q[IdxW-1:0];
      end
      wcs_pkg::SPick: begin
        if (lo_q < count_q) begin
          res_st_d = wcs_pkg::StSelected;
          res_row_d = row_rd_q;
        end
      end
      wcs_pkg::SOut: ;
      default: ;
    endcase
  end

  assign out_load = (state_q == wcs_pkg::SOut) && !(out_v_q && stall_i);

  assign valid_o = out_v_q;
  assign status_o = out_st_q;
  assign sel_weight_o = out_row_q[RowW-1 -: WB];
  assign sel_bytes_0_7_o = out_row_q[159:96];
  assign sel_bytes_8_15_o = out_row_q[95:32];
  assign sel_bytes_16_19_o = out_row_q[31:0];

endmodule
